/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

/* rtl/les_pkg.sv */
// ----------------------------------------------------------------------------
// LED strip effect package
// Shared constants, codes and types of the LED strip effect generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package les_pkg;

   // Default strip length.
   localparam int STRIP_LEN_DEF = 16;

   // Effect modes.
   localparam logic [1:0] MODE_OFF     = 2'd0;
   localparam logic [1:0] MODE_SINGLE  = 2'd1;
   localparam logic [1:0] MODE_BREATHE = 2'd2;
   localparam logic [1:0] MODE_RAINBOW = 2'd3;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_RED   = 2'd1;
   localparam logic [1:0] CSR_GREEN = 2'd2;
   localparam logic [1:0] CSR_BLUE  = 2'd3;

   // Color channel tags used by the scaling unit.
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   // Hue walk phases.
   localparam logic [2:0] PH_GREEN_UP   = 3'd0;
   localparam logic [2:0] PH_RED_DOWN   = 3'd1;
   localparam logic [2:0] PH_BLUE_UP    = 3'd2;
   localparam logic [2:0] PH_GREEN_DOWN = 3'd3;
   localparam logic [2:0] PH_RED_UP     = 3'd4;
   localparam logic [2:0] PH_BLUE_DOWN  = 3'd5;

   // Effect constants.
   localparam logic [7:0] BREATH_STEP = 8'd5;
   localparam logic [7:0] LEVEL_MAX   = 8'd255;
   localparam logic [7:0] HUE_STEP    = 8'd10;
   localparam logic [7:0] HUE_MAX     = 8'd250;

   // One pixel color.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Request into the scaling unit.
   typedef struct packed {
      logic       valid;
      logic [1:0] chan;
      logic [7:0] factor;
      logic [7:0] level;
   } scale_req_type;

   // Result of the scaling unit.
   typedef struct packed {
      logic       valid;
      logic [1:0] chan;
      logic [7:0] value;
   } scale_rsp_type;

endpackage

`default_nettype wire

/* rtl/les_scale.sv */
// ----------------------------------------------------------------------------
// LED strip channel scaler
// Two-stage unit computing floor(factor * level / 255), one channel per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module les_scale (
   input  wire                         clock,
   input  wire                         reset,
   input  wire les_pkg::scale_req_type scl_req,
   output les_pkg::scale_rsp_type      scl_rsp
);

   logic        v1_ff, v1_in;
   logic [1:0]  chan1_ff;
   logic [15:0] prod_ff;
   logic        v2_ff, v2_in;
   logic [1:0]  chan2_ff;
   logic [7:0]  quot_ff;
   logic [16:0] quot_sum;

   // Division by 255: (x + 1 + (x >> 8)) >> 8 is exact for any 8-bit by 8-bit product.
   assign quot_sum = {1'b0, prod_ff} + 17'd1 + {9'b0, prod_ff[15:8]};

   assign v1_in = scl_req.valid;
   assign v2_in = v1_ff;

   // Valid pipe.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // Product stage, then quotient stage.
   always_ff @(posedge clock) begin
      chan1_ff <= scl_req.chan;
      prod_ff  <= {8'b0, scl_req.factor} * {8'b0, scl_req.level};
      chan2_ff <= chan1_ff;
      quot_ff  <= quot_sum[15:8];
   end

   assign scl_rsp.valid = v2_ff;
   assign scl_rsp.chan  = chan2_ff;
   assign scl_rsp.value = quot_ff;

endmodule

`default_nettype wire

/* rtl/les_hue_step.sv */
// ----------------------------------------------------------------------------
// LED strip hue stepper
// Moves a rainbow color one step along the six-phase hue walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module les_hue_step (
   input  wire les_pkg::rgb_type color_cur,
   input  wire [2:0]             phase_cur,
   output les_pkg::rgb_type      color_nxt,
   output logic [2:0]            phase_nxt
);

   logic [7:0] up_val;
   logic [7:0] down_val;
   logic [7:0] sel_val;

   // Pick the channel that this phase moves.
   always_comb begin
      case (phase_cur)
         les_pkg::PH_GREEN_UP,
         les_pkg::PH_GREEN_DOWN: sel_val = color_cur.green;
         les_pkg::PH_RED_DOWN,
         les_pkg::PH_RED_UP:     sel_val = color_cur.red;
         default:                sel_val = color_cur.blue;
      endcase
   end

   // Channels wrap modulo 256.
   assign up_val   = sel_val + les_pkg::HUE_STEP;
   assign down_val = sel_val - les_pkg::HUE_STEP;

   // Apply the step and decide the phase change.
   always_comb begin
      color_nxt = color_cur;
      phase_nxt = phase_cur;
      case (phase_cur)
         les_pkg::PH_GREEN_UP: begin
            color_nxt.green = up_val;
            if (up_val >= les_pkg::HUE_MAX) phase_nxt = les_pkg::PH_RED_DOWN;
         end
         les_pkg::PH_RED_DOWN: begin
            color_nxt.red = down_val;
            if (down_val == 8'd0) phase_nxt = les_pkg::PH_BLUE_UP;
         end
         les_pkg::PH_BLUE_UP: begin
            color_nxt.blue = up_val;
            if (up_val >= les_pkg::HUE_MAX) phase_nxt = les_pkg::PH_GREEN_DOWN;
         end
         les_pkg::PH_GREEN_DOWN: begin
            color_nxt.green = down_val;
            if (down_val == 8'd0) phase_nxt = les_pkg::PH_RED_UP;
         end
         les_pkg::PH_RED_UP: begin
            color_nxt.red = up_val;
            if (up_val >= les_pkg::HUE_MAX) phase_nxt = les_pkg::PH_BLUE_DOWN;
         end
         les_pkg::PH_BLUE_DOWN: begin
            color_nxt.blue = down_val;
            if (down_val == 8'd0) phase_nxt = les_pkg::PH_GREEN_UP;
         end
         default: begin
            // Unused phases hold the color.
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/led_strip_effect_generator.sv */
// ----------------------------------------------------------------------------
// LED strip effect generator
// Frame-tick driven pixel color generator: off, single, breathing, rainbow.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the req_ stream is one frame tick; req_tdata bit 0 is the
// restart flag, which clears the pattern state before the frame is made.
// The block answers on the rsp_ stream with one item per pixel, index 0 to
// STRIP_LEN-1, and raises rsp_tlast on the final pixel. Mode off gives no
// items; single color gives one frame after each restart and then none.
// The user must write mode and color on the csr_ port only while the block
// is idle; the block itself does not enforce it. After the tick, breathing
// sends the three channels through the shared two-stage multiply and
// divide-by-255 unit, one channel issued per cycle. Pixels then leave at one
// per cycle from the output register while rsp_tready is high, the rainbow
// hue stepper advancing once per pixel; req_tready stays low until the last
// pixel is registered. A stall on rsp_tready holds the current pixel and
// pauses the sequencer. Reset clears the configuration registers, all
// pattern state and empties the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_strip_effect_generator #(
   parameter int STRIP_LEN = les_pkg::STRIP_LEN_DEF
) (
   input  wire         clock,
   input  wire         reset,
   // Frame ticks.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [0] restart, [7:1] zero
   // Pixels.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [3:0] pixel_index, [11:4] red,
                                    // [19:12] green, [27:20] blue, [31:28] zero
   output logic        rsp_tlast,
   // Configuration.
   input  wire         csr_we,
   input  wire  [1:0]  csr_addr,
   input  wire  [7:0]  csr_wdata
);

   localparam int PIX_W = (STRIP_LEN > 1) ? $clog2(STRIP_LEN) : 1;
   localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(STRIP_LEN - 1);
   localparam logic [PIX_W-1:0] SAVE_PIX = PIX_W'(1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCALE = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   // Configuration registers.
   logic [1:0] mode_ff;
   logic [7:0] cfg_red_ff, cfg_green_ff, cfg_blue_ff;

   // Pattern state.
   logic       started_ff, started_in;
   logic [7:0] level_ff, level_in;
   logic       falling_ff, falling_in;
   les_pkg::rgb_type rb_start_ff, rb_start_in;
   logic [2:0] rb_phase_ff, rb_phase_in;

   // Sequencer.
   logic [1:0]       state_ff, state_in;
   logic [1:0]       issue_ff, issue_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic             rainbow_ff, rainbow_in;
   les_pkg::rgb_type cur_ff, cur_in;
   logic [2:0]       phase_ff, phase_in;

   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic [27:0] out_data_ff, out_data_in;
   logic        out_last_ff, out_last_in;

   // Helpers.
   logic             accept;
   logic             out_free;
   logic             eff_started, eff_falling;
   logic [7:0]       eff_level;
   les_pkg::rgb_type eff_start;
   logic [2:0]       eff_phase;
   logic [8:0]       lv_up;
   logic [PIX_W+3:0] pix_ext;
   les_pkg::rgb_type hue_color;
   logic [2:0]       hue_phase;
   les_pkg::scale_req_type scl_req;
   les_pkg::scale_rsp_type scl_rsp;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;
   assign pix_ext  = {4'b0, pix_ff};

   // Shared scaling unit for breathing.
   les_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .scl_req (scl_req),
      .scl_rsp (scl_rsp)
   );

   // Hue stepper for the rainbow walk.
   les_hue_step u_hue (
      .color_cur (cur_ff),
      .phase_cur (phase_ff),
      .color_nxt (hue_color),
      .phase_nxt (hue_phase)
   );

   // Scale requests: one channel per cycle while in the scale state.
   always_comb begin
      scl_req.valid = (state_ff == ST_SCALE) && (issue_ff != 2'd3);
      scl_req.chan  = issue_ff;
      scl_req.level = level_ff;
      case (issue_ff)
         les_pkg::CH_RED:   scl_req.factor = cfg_red_ff;
         les_pkg::CH_GREEN: scl_req.factor = cfg_green_ff;
         default:           scl_req.factor = cfg_blue_ff;
      endcase
   end

   // Pattern state as seen after an optional restart.
   always_comb begin
      if (req_tdata[0]) begin
         eff_started = 1'b0;
         eff_level   = 8'd0;
         eff_falling = 1'b0;
         eff_start   = '0;
         eff_phase   = les_pkg::PH_GREEN_UP;
      end else begin
         eff_started = started_ff;
         eff_level   = level_ff;
         eff_falling = falling_ff;
         eff_start   = rb_start_ff;
         eff_phase   = rb_phase_ff;
      end
   end

   assign lv_up = {1'b0, eff_level} + {1'b0, les_pkg::BREATH_STEP};

   // Sequencer and pattern update.
   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      pix_in       = pix_ff;
      rainbow_in   = rainbow_ff;
      cur_in       = cur_ff;
      phase_in     = phase_ff;
      started_in   = started_ff;
      level_in     = level_ff;
      falling_in   = falling_ff;
      rb_start_in  = rb_start_ff;
      rb_phase_in  = rb_phase_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               started_in  = eff_started;
               level_in    = eff_level;
               falling_in  = eff_falling;
               rb_start_in = eff_start;
               rb_phase_in = eff_phase;
               pix_in      = '0;
               issue_in    = 2'd0;
               rainbow_in  = 1'b0;
               case (mode_ff)
                  les_pkg::MODE_SINGLE: begin
                     if (!eff_started) begin
                        started_in = 1'b1;
                        cur_in     = '{red: cfg_red_ff, green: cfg_green_ff,
                                       blue: cfg_blue_ff};
                        state_in   = ST_EMIT;
                     end
                  end
                  les_pkg::MODE_BREATHE: begin
                     started_in = 1'b1;
                     if (!eff_started || !eff_falling) begin
                        // Rising, also from a fresh start at level zero.
                        if (!eff_started) begin
                           level_in   = les_pkg::BREATH_STEP;
                           falling_in = 1'b0;
                        end else if (lv_up > {1'b0, les_pkg::LEVEL_MAX}) begin
                           level_in   = les_pkg::LEVEL_MAX;
                           falling_in = 1'b1;
                        end else begin
                           level_in   = lv_up[7:0];
                        end
                     end else if (eff_level < les_pkg::BREATH_STEP) begin
                        level_in   = 8'd0;
                        falling_in = 1'b0;
                     end else begin
                        level_in   = eff_level - les_pkg::BREATH_STEP;
                     end
                     state_in = ST_SCALE;
                  end
                  les_pkg::MODE_RAINBOW: begin
                     started_in = 1'b1;
                     rainbow_in = 1'b1;
                     if (!eff_started) begin
                        // A fresh walk also becomes the stored start.
                        cur_in      = '{red: les_pkg::HUE_MAX, green: 8'd0, blue: 8'd0};
                        phase_in    = les_pkg::PH_GREEN_UP;
                        rb_start_in = '{red: les_pkg::HUE_MAX, green: 8'd0, blue: 8'd0};
                        rb_phase_in = les_pkg::PH_GREEN_UP;
                     end else begin
                        cur_in   = eff_start;
                        phase_in = eff_phase;
                     end
                     state_in = ST_EMIT;
                  end
                  default: begin
                     // Mode off: only the restart takes effect.
                  end
               endcase
            end
         end

         ST_SCALE: begin
            if (scl_req.valid) issue_in = issue_ff + 2'd1;
            if (scl_rsp.valid) begin
               case (scl_rsp.chan)
                  les_pkg::CH_RED:   cur_in.red   = scl_rsp.value;
                  les_pkg::CH_GREEN: cur_in.green = scl_rsp.value;
                  default: begin
                     cur_in.blue = scl_rsp.value;
                     state_in    = ST_EMIT;
                  end
               endcase
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = {cur_ff.blue, cur_ff.green, cur_ff.red, pix_ext[3:0]};
               out_last_in  = (pix_ff == LAST_PIX);
               if (rainbow_ff) begin
                  // The next frame starts from the color of pixel one.
                  if (pix_ff == SAVE_PIX) begin
                     rb_start_in = cur_ff;
                     rb_phase_in = phase_ff;
                  end
                  cur_in   = hue_color;
                  phase_in = hue_phase;
               end
               if (pix_ff == LAST_PIX) begin
                  state_in = ST_IDLE;
               end else begin
                  pix_in = pix_ff + PIX_W'(1);
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         mode_ff      <= les_pkg::MODE_OFF;
         cfg_red_ff   <= 8'd0;
         cfg_green_ff <= 8'd0;
         cfg_blue_ff  <= 8'd0;
         started_ff   <= 1'b0;
         level_ff     <= 8'd0;
         falling_ff   <= 1'b0;
         rb_start_ff  <= '0;
         rb_phase_ff  <= les_pkg::PH_GREEN_UP;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         started_ff   <= started_in;
         level_ff     <= level_in;
         falling_ff   <= falling_in;
         rb_start_ff  <= rb_start_in;
         rb_phase_ff  <= rb_phase_in;
         if (csr_we) begin
            case (csr_addr)
               les_pkg::CSR_MODE:  mode_ff      <= csr_wdata[1:0];
               les_pkg::CSR_RED:   cfg_red_ff   <= csr_wdata;
               les_pkg::CSR_GREEN: cfg_green_ff <= csr_wdata;
               les_pkg::CSR_BLUE:  cfg_blue_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      pix_ff      <= pix_in;
      rainbow_ff  <= rainbow_in;
      cur_ff      <= cur_in;
      phase_ff    <= phase_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_data_ff};
   assign rsp_tlast  = out_last_ff;

   // Checks.
`include "assert_macros.svh"

   `ASSERT_IMPLY(a_last_index, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[3:0] == 4'(STRIP_LEN - 1))
   `ASSERT_IMPLY(a_scale_in_state, clock, reset, scl_rsp.valid, state_ff == ST_SCALE)
   `ASSERT_NEXT(a_emit_last_idle, clock, reset, state_ff == ST_EMIT && out_free && pix_ff == LAST_PIX, state_ff == ST_IDLE && rsp_tvalid && rsp_tlast)

endmodule

`default_nettype wire
